/* src/afse_pkg.sv */
// ----------------------------------------------------------------------------
// afse_pkg
// Shared types and constants for the ADTS frame sync and extract core.
// ----------------------------------------------------------------------------
package afse_pkg;

   // ADTS header size and sync pattern
   localparam int unsigned HDR_LEN       = 7;
   localparam int unsigned HDR_STORE     = 6;
   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;

   // Default depth of the command queue between front and back
   localparam int unsigned QUEUE_DEPTH   = 4;

   // Result kinds carried on rsp_tuser
   typedef enum logic [0:0] {
      KIND_BYTE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // Packet status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSYNC  = 2'd1,
      ST_TRUNC   = 2'd2
   } status_type;

   // One command from the front: a run of frame bytes, then maybe a status word
   typedef struct packed {
      logic [HDR_LEN-1:0][7:0] bytes;     // bytes to send, index 0 first
      logic [2:0]              cnt;       // number of frame bytes, 0..7
      logic                    mark_last; // tag the final byte as end of frame
      logic                    eop;       // append a status word
      status_type              status;
      logic [12:0]             length;
   } cmd_type;

endpackage

/* src/adts_frame_sync_extract_core.sv */
// ----------------------------------------------------------------------------
// adts_frame_sync_extract_core
// Finds the first ADTS sync in each packet and forwards that frame.
// ----------------------------------------------------------------------------
// Packet bytes enter on req_ one per cycle, with req_tlast on the last byte.
// The core hunts for 0xFF followed by a byte with high nibble F, collects the
// 7-byte header and forwards frame-length bytes from the sync byte (fewer if
// the packet ends first), tagging a complete frame's last byte with rsp_tlast.
// Bytes stream out as they arrive, so a frame must be dropped downstream if
// its status word reports an error. Every packet ends with one status word
// (rsp_tuser = 1): ok with length, no sync or short header, or truncated with
// length. One byte is taken per cycle while the command queue has room, and
// each byte's words pass through the command queue and the output register
// before they can be taken on rsp_. The seventh header byte expands into up
// to seven output words (eight with a status word), which leave the single
// output register one per cycle while the receiver keeps up. Bytes that follow
// it in the frame each queue one command, so the QueueDepth-entry command
// queue fills and a full replay followed by frame body stalls the input. A
// stalled receiver backs the queue up and stalls the input the same way.
// ----------------------------------------------------------------------------
module adts_frame_sync_extract_core #(
   parameter int unsigned QueueDepth = afse_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // packet byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_packet
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] frame_byte, [9:8] status,
                                    // [22:10] frame_length, [23] zero
   output logic [0:0]  rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast    // last_of_frame
);

   afse_pkg::cmd_type    front_cmd;
   afse_pkg::cmd_type    head_cmd;
   logic                 front_push;
   logic                 q_empty;
   logic                 q_full;
   logic                 q_pop;
   logic                 accept;
   afse_pkg::kind_type   out_kind;
   logic [7:0]           out_byte;
   afse_pkg::status_type out_status;
   logic [12:0]          out_length;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   afse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_packet (req_tlast),
      .push          (front_push),
      .cmd           (front_cmd)
   );

   afse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   afse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .head_valid (!q_empty),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (out_kind),
      .out_byte   (out_byte),
      .out_last   (rsp_tlast),
      .out_status (out_status),
      .out_length (out_length)
   );

   // Pack the result word
   assign rsp_tdata = {1'b0, out_length, out_status, out_byte};
   assign rsp_tuser = out_kind;

   // Status words carry no frame byte and never end a frame
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == afse_pkg::KIND_STATUS |->
         rsp_tdata[7:0] == 8'd0 && !rsp_tlast)
      else $error("status word carries byte data");

   // Frame byte words report ok with zero length
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == afse_pkg::KIND_BYTE |->
         rsp_tdata[22:8] == 15'd0)
      else $error("frame byte word carries status fields");

   // Only defined status codes leave the core
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:8] != 2'd3)
      else $error("undefined status code");

   // A short or missing header never reports a length
   a_nosync_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:8] == afse_pkg::ST_NOSYNC |->
         rsp_tdata[22:10] == 13'd0)
      else $error("no-sync status with nonzero length");

endmodule

/* src/afse_front.sv */
// ----------------------------------------------------------------------------
// afse_front
// Sync hunt and header parser. Classifies each packet byte and issues a
// command for the back end whenever the byte causes any output words.
// ----------------------------------------------------------------------------
module afse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,     // byte taken this cycle
   input  logic [7:0]        data_byte,
   input  logic              end_of_packet,
   output logic              push,
   output afse_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      MODE_HUNT,
      MODE_HEADER,
      MODE_FORWARD,
      MODE_DONE
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic        prev_ff_ff, prev_ff_in;
   logic [2:0]  count_ff, count_in;
   logic [12:0] length_ff, length_in;
   logic [12:0] sent_ff, sent_in;
   logic [7:0]  hdr_ff [afse_pkg::HDR_STORE];
   logic [7:0]  hdr_in [afse_pkg::HDR_STORE];

   logic [12:0] hdr_len;
   logic [12:0] sent_inc;

   // Frame length from header bytes 3..5
   assign hdr_len  = {hdr_ff[3][1:0], hdr_ff[4], hdr_ff[5][7:5]};
   assign sent_inc = sent_ff + 13'd1;

   // Parse one byte
   always_comb begin
      mode_in    = mode_ff;
      prev_ff_in = prev_ff_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      sent_in    = sent_ff;
      for (int i = 0; i < afse_pkg::HDR_STORE; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      cmd           = '0;
      cmd.status    = afse_pkg::ST_OK;

      unique case (mode_ff)
         MODE_HUNT: begin
            if (prev_ff_ff && data_byte[7:4] == afse_pkg::SYNC_NIBBLE) begin
               hdr_in[0]  = afse_pkg::SYNC_BYTE;
               hdr_in[1]  = data_byte;
               count_in   = 3'd2;
               mode_in    = MODE_HEADER;
               prev_ff_in = 1'b0;
            end else begin
               prev_ff_in = (data_byte == afse_pkg::SYNC_BYTE);
            end
         end
         MODE_HEADER: begin
            if (count_ff < 3'(afse_pkg::HDR_STORE)) begin
               for (int i = 0; i < afse_pkg::HDR_STORE; i++) begin
                  if (count_ff == 3'(i)) begin
                     hdr_in[i] = data_byte;
                  end
               end
               count_in = count_ff + 3'd1;
            end else begin
               // replay the header: stored bytes then the seventh byte
               for (int i = 0; i < afse_pkg::HDR_STORE; i++) begin
                  cmd.bytes[i] = hdr_ff[i];
               end
               cmd.bytes[afse_pkg::HDR_LEN-1] = data_byte;
               cmd.cnt       = (hdr_len < 13'(afse_pkg::HDR_LEN)) ?
                               hdr_len[2:0] : 3'(afse_pkg::HDR_LEN);
               cmd.mark_last = (hdr_len <= 13'(afse_pkg::HDR_LEN));
               length_in     = hdr_len;
               sent_in       = {10'd0, cmd.cnt};
               mode_in       = cmd.mark_last ? MODE_DONE : MODE_FORWARD;
            end
         end
         MODE_FORWARD: begin
            cmd.bytes[0]  = data_byte;
            cmd.cnt       = 3'd1;
            sent_in       = sent_inc;
            cmd.mark_last = (sent_inc >= length_ff);
            if (cmd.mark_last) begin
               mode_in = MODE_DONE;
            end
         end
         MODE_DONE: begin
         end
         default: begin
         end
      endcase

      // End of packet: report and go back to hunting
      if (end_of_packet) begin
         cmd.eop = 1'b1;
         unique case (mode_in)
            MODE_HUNT, MODE_HEADER: begin
               cmd.status = afse_pkg::ST_NOSYNC;
               cmd.length = '0;
            end
            MODE_FORWARD: begin
               cmd.status = afse_pkg::ST_TRUNC;
               cmd.length = length_in;
            end
            MODE_DONE: begin
               cmd.status = afse_pkg::ST_OK;
               cmd.length = length_in;
            end
            default: begin
               cmd.status = afse_pkg::ST_OK;
               cmd.length = '0;
            end
         endcase
         mode_in    = MODE_HUNT;
         prev_ff_in = 1'b0;
         count_in   = '0;
         length_in  = '0;
         sent_in    = '0;
      end
   end

   // Issue a command only when the byte produces output
   assign push = accept && (cmd.cnt != 3'd0 || cmd.eop);

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_HUNT;
         prev_ff_ff <= 1'b0;
         count_ff   <= '0;
         length_ff  <= '0;
         sent_ff    <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         prev_ff_ff <= prev_ff_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         sent_ff    <= sent_in;
      end
   end

   // Header store, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < afse_pkg::HDR_STORE; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

endmodule

/* src/afse_queue.sv */
// ----------------------------------------------------------------------------
// afse_queue
// Short command queue that decouples the parser from the output sequencer.
// ----------------------------------------------------------------------------
module afse_queue #(
   parameter int unsigned Depth = afse_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  afse_pkg::cmd_type push_cmd,
   input  logic              pop,
   output afse_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   afse_pkg::cmd_type mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CntW'(Depth));
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/afse_back.sv */
// ----------------------------------------------------------------------------
// afse_back
// Output sequencer. Expands each queued command into frame byte words and any
// status word into the output register, one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module afse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  afse_pkg::cmd_type    head,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output afse_pkg::kind_type   out_kind,
   output logic [7:0]           out_byte,
   output logic                 out_last,
   output afse_pkg::status_type out_status,
   output logic [12:0]          out_length
);

   logic [2:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   afse_pkg::kind_type   kind_ff, kind_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   afse_pkg::status_type status_ff, status_in;
   logic [12:0]          length_ff, length_in;

   logic [3:0] total;
   logic       load;
   logic       is_byte;

   assign total   = {1'b0, head.cnt} + {3'd0, head.eop};
   assign load    = head_valid && (!valid_ff || out_ready);
   assign is_byte = (idx_ff < head.cnt);
   assign pop     = load && ({1'b0, idx_ff} + 4'd1 == total);

   // Build the next output word
   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !out_ready;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      status_in = status_ff;
      length_in = length_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = pop ? 3'd0 : idx_ff + 3'd1;
         if (is_byte) begin
            kind_in   = afse_pkg::KIND_BYTE;
            byte_in   = head.bytes[idx_ff];
            last_in   = head.mark_last && (idx_ff + 3'd1 == head.cnt);
            status_in = afse_pkg::ST_OK;
            length_in = '0;
         end else begin
            kind_in   = afse_pkg::KIND_STATUS;
            byte_in   = '0;
            last_in   = 1'b0;
            status_in = head.status;
            length_in = head.length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload, no reset
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      length_ff <= length_in;
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_byte   = byte_ff;
   assign out_last   = last_ff;
   assign out_status = status_ff;
   assign out_length = length_ff;

endmodule

/* verif/adts_frame_sync_extract_core_test.sv */
// ----------------------------------------------------------------------------
// adts_frame_sync_extract_core_test
// Self-checking bench for the ADTS frame sync and extract core.
// ----------------------------------------------------------------------------
// Streams packets of bytes into the core and predicts, byte by byte, the
// frame words and the status word each packet should produce. The packets
// are mostly well-formed ADTS frames with random headers and lengths. Some
// are complete with trailing bytes, some are truncated, and the rest are
// noise or packets cut inside the header. Every output word is compared
// field by field, in order, against the prediction. The bench runs phases
// with no idling, with the sender idle, with the receiver stalling, and with
// both. One long receiver hold-off backs the core up until its input stalls.
// ----------------------------------------------------------------------------
module adts_frame_sync_extract_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned PHASE_BYTES    = 42;

   typedef enum logic [1:0] {
      PS_HUNT    = 2'd0,
      PS_HEADER  = 2'd1,
      PS_FORWARD = 2'd2,
      PS_DONE    = 2'd3
   } parse_state_type;

   typedef struct packed {
      afse_pkg::kind_type   kind;
      logic [7:0]           data;
      logic                 last;
      afse_pkg::status_type status;
      logic [12:0]          length;
   } frame_word_type;

   // Tracks the parse of each packet and holds the words still owed by the core
   class adts_extract_tracker;
      frame_word_type  expected_words[$];
      parse_state_type mode;
      logic            prev_ff;
      logic [7:0]      hdr[afse_pkg::HDR_STORE];
      int unsigned     hcnt;
      logic [12:0]     frame_len;
      logic [12:0]     sent;
      int unsigned     errors;
      int unsigned     bytes_in;
      int unsigned     packets;
      int unsigned     frame_words;
      int unsigned     status_seen[3];

      function new();
         mode = PS_HUNT;
         prev_ff = 1'b0;
         hcnt = 0;
         frame_len = '0;
         sent = '0;
         errors = 0;
         bytes_in = 0;
         packets = 0;
         frame_words = 0;
         status_seen = '{0, 0, 0};
      endfunction

      function void emit(afse_pkg::kind_type k, logic [7:0] d, logic l,
                         afse_pkg::status_type s, logic [12:0] n);
         frame_word_type w;
         w.kind = k;
         w.data = d;
         w.last = l;
         w.status = s;
         w.length = n;
         expected_words.push_back(w);
      endfunction

      // Advance the parse by one accepted byte and queue the words it causes
      function void take_byte(logic [7:0] b, logic eop);
         logic [12:0] len;
         int unsigned cnt;
         bytes_in++;
         case (mode)
            PS_HUNT: begin
               if (prev_ff && b[7:4] == afse_pkg::SYNC_NIBBLE) begin
                  hdr[0] = afse_pkg::SYNC_BYTE;
                  hdr[1] = b;
                  hcnt = 2;
                  mode = PS_HEADER;
                  prev_ff = 1'b0;
               end else begin
                  prev_ff = (b == afse_pkg::SYNC_BYTE);
               end
            end
            PS_HEADER: begin
               if (hcnt < afse_pkg::HDR_STORE) begin
                  hdr[hcnt] = b;
                  hcnt++;
               end else begin
                  // seventh header byte: replay the leading header bytes
                  len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
                  cnt = (len < afse_pkg::HDR_LEN) ? len : afse_pkg::HDR_LEN;
                  frame_len = len;
                  for (int i = 0; i < cnt; i++)
                     emit(afse_pkg::KIND_BYTE, (i < afse_pkg::HDR_STORE) ? hdr[i] : b,
                          (len <= afse_pkg::HDR_LEN) && (i + 1 == cnt),
                          afse_pkg::ST_OK, 13'd0);
                  sent = 13'(cnt);
                  if (len <= afse_pkg::HDR_LEN)
                     mode = PS_DONE;
                  else
                     mode = PS_FORWARD;
               end
            end
            PS_FORWARD: begin
               sent = sent + 13'd1;
               if (sent >= frame_len) begin
                  emit(afse_pkg::KIND_BYTE, b, 1'b1, afse_pkg::ST_OK, 13'd0);
                  mode = PS_DONE;
               end else begin
                  emit(afse_pkg::KIND_BYTE, b, 1'b0, afse_pkg::ST_OK, 13'd0);
               end
            end
            default: ;
         endcase

         // end of packet: report and go back to hunting
         if (eop) begin
            case (mode)
               PS_HUNT, PS_HEADER:
                  emit(afse_pkg::KIND_STATUS, 8'd0, 1'b0, afse_pkg::ST_NOSYNC, 13'd0);
               PS_FORWARD:
                  emit(afse_pkg::KIND_STATUS, 8'd0, 1'b0, afse_pkg::ST_TRUNC, frame_len);
               default:
                  emit(afse_pkg::KIND_STATUS, 8'd0, 1'b0, afse_pkg::ST_OK, frame_len);
            endcase
            packets++;
            mode = PS_HUNT;
            prev_ff = 1'b0;
            hcnt = 0;
            frame_len = '0;
            sent = '0;
         end
      endfunction

      // Compare one output word with the oldest expected word
      function void check_word(logic kind, logic [7:0] data, logic last,
                               logic [1:0] st, logic [12:0] len, logic pad);
         frame_word_type w;
         if (expected_words.size() == 0) begin
            $error("unexpected output word: kind %0d data %0h status %0d length %0d",
                   kind, data, st, len);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (w.kind != kind) begin
            $error("result_kind: expected %0d, got %0d", w.kind, kind);
            errors++;
         end
         if (w.data != data) begin
            $error("frame_byte: expected %0h, got %0h", w.data, data);
            errors++;
         end
         if (w.last != last) begin
            $error("last_of_frame: expected %0d, got %0d", w.last, last);
            errors++;
         end
         if (w.status != st) begin
            $error("status: expected %0d, got %0d", w.status, st);
            errors++;
         end
         if (w.length != len) begin
            $error("frame_length: expected %0d, got %0d", w.length, len);
            errors++;
         end
         if (pad !== 1'b0) begin
            $error("tdata pad bit: expected 0, got %0b", pad);
            errors++;
         end
         if (w.kind == afse_pkg::KIND_STATUS)
            status_seen[w.status]++;
         else
            frame_words++;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // end_of_packet
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] frame_byte, [9:8] status,
                                    // [22:10] frame_length, [23] zero
   logic [0:0]  rsp_tuser;          // [0] result_kind
   logic        rsp_tlast;          // last_of_frame

   adts_extract_tracker tracker = new();
   logic [7:0]  pkt[$];
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_armed = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   adts_frame_sync_extract_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: check accepted words, stall at random, hold off once when armed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_word(rsp_tuser[0], rsp_tdata[7:0], rsp_tlast, rsp_tdata[9:8],
                            rsp_tdata[22:10], rsp_tdata[23]);
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: stop when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still owed",
                     quiet_cycles, tracker.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Offer one byte, with random idle cycles ahead of it, until accepted
   task automatic send_byte(input logic [7:0] b, input logic eop);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eop;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      tracker.take_byte(b, eop);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++)
         send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   // Append a 7-byte ADTS header for the given frame length, other bits random
   task automatic add_header(input logic [12:0] len);
      pkt.push_back(afse_pkg::SYNC_BYTE);
      pkt.push_back({afse_pkg::SYNC_NIBBLE, 4'($urandom_range(0, 15))});
      pkt.push_back(8'($urandom));
      pkt.push_back({6'($urandom), len[12:11]});
      pkt.push_back(len[10:3]);
      pkt.push_back({len[2:0], 5'($urandom)});
      pkt.push_back(8'($urandom));
   endtask

   // Build one random packet: mostly frames, some noise and cut headers
   task automatic make_random_packet();
      int unsigned sel;
      int unsigned body;
      int unsigned n;
      logic [12:0] len;
      pkt.delete();
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         n = $urandom_range(1, 10);
         repeat (n)
            pkt.push_back(($urandom_range(0, 3) == 0) ? afse_pkg::SYNC_BYTE : 8'($urandom));
      end else if (sel < 20) begin
         repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
         pkt.push_back(afse_pkg::SYNC_BYTE);
         pkt.push_back({afse_pkg::SYNC_NIBBLE, 4'($urandom_range(0, 15))});
         repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
         sel = $urandom_range(0, 99);
         if (sel < 20)
            len = 13'($urandom_range(0, afse_pkg::HDR_LEN));
         else if (sel < 85)
            len = 13'($urandom_range(afse_pkg::HDR_LEN + 1, 20));
         else
            len = 13'($urandom);
         add_header(len);
         body = (len > afse_pkg::HDR_LEN) ? len - afse_pkg::HDR_LEN : 0;
         if (body > 0 && (len > 24 || $urandom_range(0, 3) == 0)) begin
            // truncated: stop short of the frame's end
            n = $urandom_range(0, (body - 1 < 16) ? body - 1 : 16);
            repeat (n) pkt.push_back(8'($urandom));
         end else begin
            repeat (body) pkt.push_back(8'($urandom));
            repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
         end
      end
   endtask

   initial begin
      int unsigned idle_tbl[4];
      int unsigned stall_tbl[4];
      int unsigned phase_start;
      idle_tbl = '{0, 53, 0, 14};
      stall_tbl = '{0, 0, 53, 14};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // lone 0xFF ending the packet: no sync
      pkt = {8'hFF};
      send_packet();
      // sync on the first of two 0xFF bytes, packet ends inside the header
      pkt = {8'hFF, 8'hFF, 8'hF3};
      send_packet();
      // zero length frame, then a trailing byte that is ignored
      pkt = {8'hFF, 8'hF0, 8'h5A, 8'hFC, 8'h00, 8'h1F, 8'hA5, 8'hAB};
      send_packet();
      // length three, packet ends on the seventh header byte
      pkt = {8'hFF, 8'hF1, 8'h00, 8'h00, 8'h00, 8'h60, 8'h77};
      send_packet();
      // maximum length, full header replay, then truncated
      pkt = {8'hFF, 8'hFF, 8'hF8, 8'h03, 8'hFF, 8'hE0, 8'hC3, 8'h80};
      send_packet();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_tbl[ph];
         stall_pct <= stall_tbl[ph];
         phase_start = tracker.bytes_in;
         if (ph == 0) begin
            // long hold-off while a long frame keeps coming in
            hold_armed <= 1'b1;
            pkt.delete();
            add_header(13'd48);
            repeat (41) pkt.push_back(8'($urandom));
            send_packet();
         end
         while (tracker.bytes_in - phase_start < PHASE_BYTES) begin
            make_random_packet();
            send_packet();
         end
      end
      req_tvalid <= 1'b0;

      // drain, then let any stray word show up
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d bytes in %0d packets: %0d frame words,",
               tracker.bytes_in, tracker.packets, tracker.frame_words);
      $display("  status ok %0d, no sync %0d, truncated %0d",
               tracker.status_seen[afse_pkg::ST_OK],
               tracker.status_seen[afse_pkg::ST_NOSYNC],
               tracker.status_seen[afse_pkg::ST_TRUNC]);
      $display("Idling ran none, sender 53%%, receiver 53%%, both 14%%, plus one %0d-cycle hold-off",
               HOLD_CYCLES);
      if (tracker.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
